[design/edfrq_pkg.sv]
`default_nettype none

package edfrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DL_W        = 32;
  localparam int ID_W        = 8;
  localparam int ERR_W       = 2;

  localparam logic CMD_READY = 1'b0;
  localparam logic CMD_DONE  = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_FOUND = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input word
    logic exec;   // insert / remove in the queue
    logic fire;   // dispatch rule and write of the output register
  } edfrq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } edfrq_stat_t;

endpackage

`default_nettype wire

[design/edfrq_ctrl.sv]
`default_nettype none

module edfrq_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   out_stall,
  input  wire edfrq_pkg::edfrq_stat_t stat,
  output edfrq_pkg::edfrq_cmd_t       cmd
);
  import edfrq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DISP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_free;
  logic       in_accept;

  // output slot is free when empty or being taken this cycle
  assign out_free  = !stat.out_busy || !out_stall;
  // no word is taken while in reset
  assign in_stall  = !rst_n ||
                     !((state_r == ST_IDLE) || ((state_r == ST_DISP) && out_free));
  assign in_accept = in_valid && !in_stall;

  assign cmd.load = in_accept;
  assign cmd.exec = (state_r == ST_EXEC);
  assign cmd.fire = (state_r == ST_DISP) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (out_free) state_nxt = in_accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (state_r == ST_IDLE) || (state_r == ST_DISP))
    else $error("word accepted while busy");

  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> cmd.exec)
    else $error("accepted word not executed next cycle");

  a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |-> !(stat.out_busy && out_stall))
    else $error("output overwritten while stalled");
`endif

endmodule

`default_nettype wire

[design/edfrq_dpath.sv]
`default_nettype none

module edfrq_dpath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire edfrq_pkg::edfrq_cmd_t          cmd,
  output edfrq_pkg::edfrq_stat_t              stat,
  input  wire logic                           in_cmd,
  input  wire logic [edfrq_pkg::ID_W-1:0]     in_task_id,
  input  wire logic [edfrq_pkg::DL_W-1:0]     in_abs_deadline,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic                                out_dispatch_valid,
  output logic [edfrq_pkg::ID_W-1:0]          out_dispatch_id,
  output logic                                out_demote_valid,
  output logic [edfrq_pkg::ID_W-1:0]          out_demote_id,
  output logic [edfrq_pkg::CNT_W-1:0]         out_queue_count,
  output logic [edfrq_pkg::ERR_W-1:0]         out_error_code
);
  import edfrq_pkg::*;

  localparam logic [QUEUE_DEPTH-1:0] ONES = '1;

  // captured input word
  logic             cmd_r;
  logic [ID_W-1:0]  id_r;
  logic [DL_W-1:0]  dl_r;

  // queue, sorted by deadline, head at index 0
  logic [DL_W-1:0]        dl_q    [QUEUE_DEPTH];
  logic [ID_W-1:0]        task_q  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] started_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  logic             run_r;
  logic             run_nxt;
  logic [ERR_W-1:0] err_r;
  logic [ERR_W-1:0] err_nxt;

  logic                   out_valid_r;
  logic                   disp_valid_r;
  logic [ID_W-1:0]        disp_id_r;
  logic                   dem_valid_r;
  logic [ID_W-1:0]        dem_id_r;
  logic [CNT_W-1:0]       qcount_r;
  logic [ERR_W-1:0]       ecode_r;

  logic [QUEUE_DEPTH-1:0] mark_v;   // entry k sits at or after the insert point
  logic [QUEUE_DEPTH-1:0] prev_v;   // mark of entry k-1
  logic [QUEUE_DEPTH-1:0] match_v;
  logic [QUEUE_DEPTH-1:0] seen_v;   // first match at or below k
  logic                   full;
  logic                   found;
  logic                   do_ins;
  logic                   do_rem;
  logic                   disp_go;
  logic                   dem_go;

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      mark_v[k]  = !(CNT_W'(k) < count_r) || (dl_r < dl_q[k]);
      match_v[k] = (CNT_W'(k) < count_r) && (task_q[k] == id_r);
    end
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      seen_v[k] = |(match_v & (ONES >> (QUEUE_DEPTH - 1 - k)));
    end
  end

  assign prev_v = {mark_v[QUEUE_DEPTH-2:0], 1'b0};
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign found  = |match_v;
  assign do_ins = cmd.exec && (cmd_r == CMD_READY) && !full;
  assign do_rem = cmd.exec && (cmd_r == CMD_DONE) && found;

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CNT_W'(1);
    else if (do_rem) count_nxt = count_r - CNT_W'(1);
  end

  always_comb begin
    priority if (cmd_r == CMD_READY) begin
      err_nxt = full ? ERR_FULL : ERR_OK;
      run_nxt = !full && mark_v[0];
    end else begin
      err_nxt = found ? ERR_OK : ERR_NOT_FOUND;
      run_nxt = found;
    end
  end

  assign disp_go = run_r && (count_r != '0) && !started_r[0];
  assign dem_go  = run_r && (count_r >= CNT_W'(2)) && started_r[1];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : gen_entry
    logic [DL_W-1:0] dl_prev;
    logic [ID_W-1:0] task_prev;
    logic            st_prev;
    logic [DL_W-1:0] dl_next;
    logic [ID_W-1:0] task_next;
    logic            st_next;
    logic [DL_W-1:0] dl_nxt;
    logic [ID_W-1:0] task_nxt;
    logic            st_nxt;

    if (g == 0) begin : gen_head
      assign dl_prev   = '0;
      assign task_prev = '0;
      assign st_prev   = 1'b0;
    end else begin : gen_body
      assign dl_prev   = dl_q[g-1];
      assign task_prev = task_q[g-1];
      assign st_prev   = started_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : gen_tail
      assign dl_next   = dl_q[g];
      assign task_next = task_q[g];
      assign st_next   = 1'b0;
    end else begin : gen_mid
      assign dl_next   = dl_q[g+1];
      assign task_next = task_q[g+1];
      assign st_next   = started_r[g+1];
    end

    always_comb begin
      dl_nxt   = dl_q[g];
      task_nxt = task_q[g];
      st_nxt   = started_r[g];
      if (do_ins) begin
        if (mark_v[g] && !prev_v[g]) begin
          dl_nxt   = dl_r;
          task_nxt = id_r;
          st_nxt   = 1'b0;
        end else if (prev_v[g]) begin
          dl_nxt   = dl_prev;
          task_nxt = task_prev;
          st_nxt   = st_prev;
        end
      end else if (do_rem) begin
        if (seen_v[g]) begin
          dl_nxt   = dl_next;
          task_nxt = task_next;
          st_nxt   = st_next;
        end
      end else if (cmd.fire && disp_go && (g == 0)) begin
        st_nxt = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      dl_q[g]   <= dl_nxt;
      task_q[g] <= task_nxt;
      if (!rst_n) begin
        started_r[g] <= 1'b0;
      end else begin
        started_r[g] <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      id_r  <= in_task_id;
      dl_r  <= in_abs_deadline;
    end
    if (cmd.exec) begin
      err_r <= err_nxt;
    end
    if (cmd.fire) begin
      disp_valid_r <= disp_go;
      disp_id_r    <= disp_go ? task_q[0] : '0;
      dem_valid_r  <= dem_go;
      dem_id_r     <= dem_go ? task_q[1] : '0;
      qcount_r     <= count_r;
      ecode_r      <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.exec) run_r <= run_nxt;
      if (cmd.fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign stat.out_busy      = out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_dispatch_valid = disp_valid_r;
  assign out_dispatch_id    = disp_id_r;
  assign out_demote_valid   = dem_valid_r;
  assign out_demote_id      = dem_id_r;
  assign out_queue_count    = qcount_r;
  assign out_error_code     = ecode_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (err_nxt != ERR_OK)) |=> (count_r == $past(count_r)))
    else $error("failed command changed the queue count");

  a_dispatch_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fire && disp_go) |=> started_r[0])
    else $error("dispatched head not marked started");
`endif

endmodule

`default_nettype wire

[design/edf_ready_queue_dispatch.sv]
// EDF ready queue with dispatch.
// Input channel (in_valid / in_stall): one word per scheduling event;
// in_cmd selects insert (task ready) or remove (task completed) of in_task_id,
// in_abs_deadline orders inserts, smallest first, ties in arrival order.
// Output channel (out_valid / out_stall): exactly one word per input word,
// carrying dispatch and demotion reports, the queue count after the event
// and an error code (queue full, task not found).
// Each accepted word is captured, inserted or removed in the EXEC state, and
// then the dispatch rule in the DISP state writes the output register; the queue
// is a shift register, and no new word is taken while a word is in EXEC.
// The next input word is taken in the same cycle the result is registered.
// When the receiver stalls, the result holds in the output register and a
// following word is taken and executed, then waits until the register frees.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; no input word is taken while reset is asserted.
`default_nettype none

module edf_ready_queue_dispatch (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_cmd,
  input  wire logic [edfrq_pkg::ID_W-1:0]     in_task_id,
  input  wire logic [edfrq_pkg::DL_W-1:0]     in_abs_deadline,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_dispatch_valid,
  output logic [edfrq_pkg::ID_W-1:0]          out_dispatch_id,
  output logic                                out_demote_valid,
  output logic [edfrq_pkg::ID_W-1:0]          out_demote_id,
  output logic [edfrq_pkg::CNT_W-1:0]         out_queue_count,
  output logic [edfrq_pkg::ERR_W-1:0]         out_error_code
);
  import edfrq_pkg::*;

  edfrq_cmd_t  cmd;
  edfrq_stat_t stat;

  edfrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  edfrq_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_cmd             (in_cmd),
    .in_task_id         (in_task_id),
    .in_abs_deadline    (in_abs_deadline),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_dispatch_valid (out_dispatch_valid),
    .out_dispatch_id    (out_dispatch_id),
    .out_demote_valid   (out_demote_valid),
    .out_demote_id      (out_demote_id),
    .out_queue_count    (out_queue_count),
    .out_error_code     (out_error_code)
  );

endmodule

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;
  import edfrq_pkg::*;

  typedef struct packed {
    logic                 dsp_v;
    logic [ID_W-1:0]      dsp_id;
    logic                 dem_v;
    logic [ID_W-1:0]      dem_id;
    logic [CNT_W-1:0]     count;
    logic [ERR_W-1:0]     err;
  } report_t;

  typedef struct packed {
    logic            c;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
    logic            typed;
    report_t         rep;
  } dir_row_t;

  localparam report_t NO_REP    = '0;
  localparam int      DIR_N     = 25;
  localparam int      PHASE_N   = 4;
  localparam int      PHASE_LEN = 360;
  localparam int      HOLD_LEN  = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = CMD_READY;
  logic [ID_W-1:0] in_task_id = '0;
  logic [DL_W-1:0] in_abs_deadline = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_dispatch_valid;
  logic [ID_W-1:0] out_dispatch_id;
  logic out_demote_valid;
  logic [ID_W-1:0] out_demote_id;
  logic [CNT_W-1:0] out_queue_count;
  logic [ERR_W-1:0] out_error_code;

  // expectation typed into the table travels with its word
  logic    word_typed = 1'b0;
  report_t word_rep = '0;

  edf_ready_queue_dispatch u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_task_id         (in_task_id),
    .in_abs_deadline    (in_abs_deadline),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_dispatch_valid (out_dispatch_valid),
    .out_dispatch_id    (out_dispatch_id),
    .out_demote_valid   (out_demote_valid),
    .out_demote_id      (out_demote_id),
    .out_queue_count    (out_queue_count),
    .out_error_code     (out_error_code)
  );

  always #4 clk = ~clk;

  // shadow of the ready queue
  logic [DL_W-1:0] q_dl [QUEUE_DEPTH];
  logic [ID_W-1:0] q_id [QUEUE_DEPTH];
  logic            q_st [QUEUE_DEPTH] = '{default: 1'b0};
  int              q_cnt = 0;

  report_t pending_reports [$];
  int      fail_cnt = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      ins_pct = 55;
  int      hold_reqs = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  function automatic report_t report_of(logic dv, logic [ID_W-1:0] did, logic mv,
                                        logic [ID_W-1:0] mid, int cnt,
                                        logic [ERR_W-1:0] err);
    report_t r;
    r.dsp_v  = dv;
    r.dsp_id = did;
    r.dem_v  = mv;
    r.dem_id = mid;
    r.count  = cnt[CNT_W-1:0];
    r.err    = err;
    return r;
  endfunction

  function automatic report_t edf_schedule(logic c, logic [ID_W-1:0] id, logic [DL_W-1:0] dl);
    report_t r;
    int      pos;
    int      k;
    logic    run_rule;
    r = '0;
    run_rule = 1'b0;
    pos = 0;
    if (c == CMD_READY) begin
      if (q_cnt >= QUEUE_DEPTH) begin
        r.err = ERR_FULL;
      end else begin
        // ties go behind, so only a strictly later deadline stops the scan
        while (pos < q_cnt && !(dl < q_dl[pos])) pos++;
        for (k = q_cnt; k > pos; k--) begin
          q_dl[k] = q_dl[k-1];
          q_id[k] = q_id[k-1];
          q_st[k] = q_st[k-1];
        end
        q_dl[pos] = dl;
        q_id[pos] = id;
        q_st[pos] = 1'b0;
        q_cnt++;
        run_rule = (pos == 0);
      end
    end else begin
      while (pos < q_cnt && q_id[pos] != id) pos++;
      if (pos >= q_cnt) begin
        r.err = ERR_NOT_FOUND;
      end else begin
        for (k = pos + 1; k < q_cnt; k++) begin
          q_dl[k-1] = q_dl[k];
          q_id[k-1] = q_id[k];
          q_st[k-1] = q_st[k];
        end
        q_cnt--;
        q_st[q_cnt] = 1'b0;
        run_rule = 1'b1;
      end
    end
    if (run_rule && q_cnt > 0) begin
      if (!q_st[0]) begin
        q_st[0] = 1'b1;
        r.dsp_v = 1'b1;
        r.dsp_id = q_id[0];
      end
      if (q_cnt >= 2 && q_st[1]) begin
        r.dem_v = 1'b1;
        r.dem_id = q_id[1];
      end
    end
    r.count = q_cnt[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // one process for both channels, so a push and a pop never race
  always @(posedge clk) begin
    report_t want;
    report_t got;
    if (rst_n && in_valid && !in_stall) begin
      want = edf_schedule(in_cmd, in_task_id, in_abs_deadline);
      if (word_typed) want = word_rep;
      pending_reports.push_back(want);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = {out_dispatch_valid, out_dispatch_id, out_demote_valid, out_demote_id,
             out_queue_count, out_error_code};
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected word: expected none, got %h", $time, got);
        fail_cnt++;
      end else begin
        want = pending_reports.pop_front();
        check_field("dispatch_valid", want.dsp_v, got.dsp_v);
        check_field("dispatch_id", want.dsp_id, got.dsp_id);
        check_field("demote_valid", want.dem_v, got.dem_v);
        check_field("demote_id", want.dem_id, got.dem_id);
        check_field("queue_count", want.count, got.count);
        check_field("error_code", want.err, got.err);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic put_word(logic c, logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
                          logic typed, report_t rep);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_task_id <= id;
    in_abs_deadline <= dl;
    word_typed <= typed;
    word_rep <= rep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pick_word(output logic c, output logic [ID_W-1:0] id,
                           output logic [DL_W-1:0] dl);
    dl = $urandom;
    if ($urandom_range(99) < ins_pct) begin
      c = CMD_READY;
      // small ids give duplicates, small deadlines give ties
      id = ($urandom_range(9) < 7) ? ID_W'($urandom_range(31)) : ID_W'($urandom_range(255));
      case ($urandom_range(9))
        0, 1, 2, 3, 4: dl = $urandom_range(15);
        8:             dl = '0;
        9:             dl = '1;
        default:       dl = $urandom;
      endcase
    end else begin
      c = CMD_DONE;
      if (q_cnt > 0 && $urandom_range(9) < 8) id = q_id[$urandom_range(q_cnt - 1)];
      else id = ID_W'($urandom_range(255));
    end
  endtask

  initial begin
    dir_row_t        dir_tab [DIR_N];
    int              phase_idle [PHASE_N];
    int              phase_stall [PHASE_N];
    int              ph;
    int              n;
    logic            c;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;

    phase_idle = '{0, 53, 0, 13};
    phase_stall = '{0, 0, 53, 13};
    dir_tab = '{
      '{CMD_DONE,  8'h05, 32'h0000_0000, 1'b1, report_of(0, 0, 0, 0, 0, ERR_NOT_FOUND)},
      '{CMD_READY, 8'h00, 32'hFFFF_FFFF, 1'b1, report_of(1, 8'h00, 0, 0, 1, ERR_OK)},
      '{CMD_READY, 8'hFF, 32'h0000_0000, 1'b1, report_of(1, 8'hFF, 1, 8'h00, 2, ERR_OK)},
      '{CMD_READY, 8'h11, 32'h0000_0000, 1'b1, report_of(0, 0, 0, 0, 3, ERR_OK)},
      '{CMD_READY, 8'h22, 32'h8000_0000, 1'b0, NO_REP},
      '{CMD_READY, 8'h11, 32'h0000_0005, 1'b0, NO_REP},
      '{CMD_DONE,  8'hFF, 32'h0000_0000, 1'b0, NO_REP},
      '{CMD_DONE,  8'h11, 32'h0000_0000, 1'b0, NO_REP},
      '{CMD_READY, 8'h40, 32'h0000_0001, 1'b0, NO_REP},
      '{CMD_READY, 8'h81, 32'h0000_0100, 1'b0, NO_REP},
      '{CMD_READY, 8'h82, 32'h0000_0100, 1'b0, NO_REP},
      '{CMD_READY, 8'h83, 32'h7FFF_FFFF, 1'b0, NO_REP},
      '{CMD_READY, 8'h84, 32'hFFFF_FFFF, 1'b0, NO_REP},
      '{CMD_READY, 8'h85, 32'h0000_0002, 1'b0, NO_REP},
      '{CMD_READY, 8'h86, 32'h0000_0003, 1'b0, NO_REP},
      '{CMD_READY, 8'h87, 32'h0000_0004, 1'b0, NO_REP},
      '{CMD_READY, 8'h88, 32'h1234_5678, 1'b0, NO_REP},
      '{CMD_READY, 8'h89, 32'h0000_0006, 1'b0, NO_REP},
      '{CMD_READY, 8'h8A, 32'h0000_0007, 1'b0, NO_REP},
      '{CMD_READY, 8'h8B, 32'h0000_0008, 1'b0, NO_REP},
      '{CMD_READY, 8'h8C, 32'h0000_0009, 1'b0, NO_REP},
      '{CMD_READY, 8'h8D, 32'h0000_0000, 1'b1, report_of(0, 0, 0, 0, 16, ERR_FULL)},
      '{CMD_DONE,  8'h8D, 32'h0000_0000, 1'b1, report_of(0, 0, 0, 0, 16, ERR_NOT_FOUND)},
      '{CMD_DONE,  8'h84, 32'h0000_0000, 1'b0, NO_REP},
      '{CMD_DONE,  8'h40, 32'h0000_0000, 1'b0, NO_REP}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIR_N; n++) begin
      put_word(dir_tab[n].c, dir_tab[n].id, dir_tab[n].dl, dir_tab[n].typed, dir_tab[n].rep);
    end

    for (ph = 0; ph < PHASE_N; ph++) begin
      idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (n = 0; n < PHASE_LEN; n++) begin
        if (n % 90 == 0) begin
          case ($urandom_range(2))
            0:       ins_pct = 30;
            1:       ins_pct = 55;
            default: ins_pct = 85;
          endcase
        end
        // long receiver hold while words keep coming: fills the pipe
        if (ph == 0 && n == 40) hold_reqs++;
        pick_word(c, id, dl);
        put_word(c, id, dl, 1'b0, NO_REP);
      end
      in_valid <= 1'b0;
      @(posedge clk);
      wait (pending_reports.size() == 0);
      @(posedge clk);
    end

    repeat (6) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS edf_ready_queue_dispatch");
    end else begin
      $display("FAIL edf_ready_queue_dispatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL edf_ready_queue_dispatch");
    $finish;
  end

endmodule

`default_nettype wire
